>>> rtl/u8u16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helpers of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SPACE_UNIT   = 16'h0020;
    localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
    localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // One command per input item that produces output: a run of replacement
    // units followed by up to two literal units.
    typedef struct packed {
        logic [2:0]  repl_cnt;
        logic [1:0]  tail_cnt;
        logic [15:0] tail0;
        logic [15:0] tail1;
        logic        last;
    } cmd_t;

    // Sequence length announced by a lead byte's bit pattern; zero for a byte that fits no lead pattern.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // True for a code point in the surrogate range.
    function automatic logic is_surrogate(input logic [15:0] cp);
        return cp[15:11] == 5'b11011;
    endfunction

endpackage
`default_nettype wire

>>> rtl/u8u16_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, tracks the pending sequence and classifies each item into
// a command for the output side.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_in_byte,
    input  wire logic            s_final_byte,
    input  wire logic            q_full,
    output logic                 q_push,
    output u8u16_pkg::cmd_t      q_cmd
);

    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic [2:0]  exp_reg, exp_next;

    logic        accept;
    logic        is_cont;
    logic [2:0]  len;
    logic [15:0] fresh_unit;
    logic        fresh_hold;
    logic        take_fresh;
    logic        clear;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [20:0] supp;
    u8u16_pkg::cmd_t cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_cont = (s_in_byte[7:6] == 2'b10);
    assign len     = u8u16_pkg::lead_len(s_in_byte);

    assign cp3  = {held_reg[0][3:0], held_reg[1][5:0], s_in_byte[5:0]};
    assign cp4  = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], s_in_byte[5:0]};
    assign supp = cp4 - u8u16_pkg::SUPP_BASE;

    always_comb begin
        fresh_hold = 1'b0;
        fresh_unit = u8u16_pkg::REPL_UNIT;
        priority if (s_in_byte == 8'h00) begin
            fresh_unit = u8u16_pkg::SPACE_UNIT;
        end else if (len == 3'd0) begin
            fresh_unit = u8u16_pkg::REPL_UNIT;
        end else if (len == 3'd1) begin
            fresh_unit = {8'h00, s_in_byte};
        end else if (s_final_byte) begin
            fresh_unit = u8u16_pkg::REPL_UNIT;
        end else begin
            fresh_hold = 1'b1;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.last   = s_final_byte;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        clear      = 1'b0;
        take_fresh = 1'b0;

        if (cnt_reg != 2'd0) begin
            if (is_cont) begin
                if (({1'b0, cnt_reg} + 3'd1) >= exp_reg) begin
                    clear = 1'b1;
                    unique case (exp_reg)
                        3'd2: begin
                            if (held_reg[0] < u8u16_pkg::LEAD2_MIN) begin
                                cmd.repl_cnt = 3'd2;
                            end else begin
                                cmd.tail_cnt = 2'd1;
                                cmd.tail0    = {5'b0, held_reg[0][4:0], s_in_byte[5:0]};
                            end
                        end
                        3'd3: begin
                            if (u8u16_pkg::is_surrogate(cp3)) begin
                                cmd.repl_cnt = 3'd1;
                            end else begin
                                cmd.tail_cnt = 2'd1;
                                cmd.tail0    = cp3;
                            end
                        end
                        3'd4: begin
                            if (held_reg[0] > u8u16_pkg::LEAD4_MAX) begin
                                cmd.repl_cnt = 3'd4;
                            end else if (cp4[20:16] == 5'd0) begin
                                if (u8u16_pkg::is_surrogate(cp4[15:0])) begin
                                    cmd.repl_cnt = 3'd1;
                                end else begin
                                    cmd.tail_cnt = 2'd1;
                                    cmd.tail0    = cp4[15:0];
                                end
                            end else if (cp4 <= u8u16_pkg::CP_MAX) begin
                                cmd.tail_cnt = 2'd2;
                                cmd.tail0    = u8u16_pkg::HI_SURR_BASE | {6'b0, supp[19:10]};
                                cmd.tail1    = u8u16_pkg::LO_SURR_BASE | {6'b0, supp[9:0]};
                            end else begin
                                cmd.repl_cnt = 3'd1;
                            end
                        end
                        default: begin
                            cmd.repl_cnt = 3'd1;
                        end
                    endcase
                end else if (s_final_byte) begin
                    // Sequence cut short: one replacement per byte, this one included.
                    cmd.repl_cnt = {1'b0, cnt_reg} + 3'd1;
                    clear        = 1'b1;
                end else begin
                    if (cnt_reg == 2'd1) begin
                        held_next[1] = s_in_byte;
                    end else begin
                        held_next[2] = s_in_byte;
                    end
                    cnt_next = cnt_reg + 2'd1;
                end
            end else begin
                // Broken sequence: flush the held bytes, then treat this byte as new.
                cmd.repl_cnt = {1'b0, cnt_reg};
                clear        = 1'b1;
                take_fresh   = 1'b1;
            end
        end else begin
            take_fresh = 1'b1;
        end

        if (clear || s_final_byte) begin
            held_next[0] = 8'h00;
            held_next[1] = 8'h00;
            held_next[2] = 8'h00;
            cnt_next     = 2'd0;
            exp_next     = 3'd0;
        end

        if (take_fresh) begin
            if (fresh_hold) begin
                held_next[0] = s_in_byte;
                cnt_next     = 2'd1;
                exp_next     = len;
            end else begin
                cmd.tail_cnt = 2'd1;
                cmd.tail0    = fresh_unit;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && ((cmd.repl_cnt != 3'd0) || (cmd.tail_cnt != 2'd0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg[0] <= 8'h00;
            held_reg[1] <= 8'h00;
            held_reg[2] <= 8'h00;
            cnt_reg     <= 2'd0;
            exp_reg     <= 3'd0;
        end else if (accept) begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            exp_reg  <= exp_next;
        end
    end

`ifndef SYNTHESIS
    a_fin_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_final_byte) |-> q_push)
        else $error("final item produced no command");
    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_final_byte) |=> (cnt_reg == 2'd0 && exp_reg == 3'd0))
        else $error("pending sequence survived a final item");
`endif

endmodule
`default_nettype wire

>>> rtl/u8u16_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_queue
// Small command FIFO between the classifying front and the output back.
// ----------------------------------------------------------------------------
module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire u8u16_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output u8u16_pkg::cmd_t      head_cmd
);

    // DEPTH must be a power of two so the pointers wrap on their own.
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8u16_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("command queue underflow");
`endif

endmodule
`default_nettype wire

>>> rtl/u8u16_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// Expands commands into UTF-16 code units in the output register, one per
// cycle while m_ready does not stall it.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            head_valid,
    input  wire u8u16_pkg::cmd_t head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [15:0]          m_code_unit,
    output logic                 m_end_of_string
);

    logic        active_reg, active_next;
    logic [2:0]  repl_left_reg, repl_left_next;
    logic [1:0]  tail_left_reg, tail_left_next;
    logic [15:0] tail0_reg, tail0_next;
    logic [15:0] tail1_reg, tail1_next;
    logic        last_reg, last_next;
    logic        valid_reg, valid_next;
    logic [15:0] code_reg, code_next;
    logic        eos_reg, eos_next;

    logic out_ok;
    logic emit;
    logic last_unit;

    assign out_ok    = !valid_reg || m_ready;
    assign emit      = active_reg && out_ok;
    assign last_unit = (repl_left_reg == 3'd1 && tail_left_reg == 2'd0)
                    || (repl_left_reg == 3'd0 && tail_left_reg == 2'd1);
    assign pop       = head_valid && (!active_reg || (emit && last_unit));

    always_comb begin
        active_next    = active_reg;
        repl_left_next = repl_left_reg;
        tail_left_next = tail_left_reg;
        tail0_next     = tail0_reg;
        tail1_next     = tail1_reg;
        last_next      = last_reg;
        valid_next     = valid_reg;
        code_next      = code_reg;
        eos_next       = eos_reg;

        if (emit) begin
            valid_next = 1'b1;
            eos_next   = last_reg && last_unit;
            if (repl_left_reg != 3'd0) begin
                code_next      = u8u16_pkg::REPL_UNIT;
                repl_left_next = repl_left_reg - 3'd1;
            end else begin
                code_next      = tail0_reg;
                tail0_next     = tail1_reg;
                tail_left_next = tail_left_reg - 2'd1;
            end
            if (last_unit) begin
                active_next = 1'b0;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end

        if (pop) begin
            active_next    = 1'b1;
            repl_left_next = head_cmd.repl_cnt;
            tail_left_next = head_cmd.tail_cnt;
            tail0_next     = head_cmd.tail0;
            tail1_next     = head_cmd.tail1;
            last_next      = head_cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
        repl_left_reg <= repl_left_next;
        tail_left_reg <= tail_left_next;
        tail0_reg     <= tail0_next;
        tail1_reg     <= tail1_next;
        last_reg      <= last_next;
        code_reg      <= code_next;
        eos_reg       <= eos_next;
    end

    assign m_valid         = valid_reg;
    assign m_code_unit     = code_reg;
    assign m_end_of_string = eos_reg;

`ifndef SYNTHESIS
    a_active_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (repl_left_reg != 3'd0 || tail_left_reg != 2'd0))
        else $error("active command with no units left");
    a_cmd_size: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> ((head_cmd.repl_cnt + 3'(head_cmd.tail_cnt)) != 3'd0
              && (head_cmd.repl_cnt + 3'(head_cmd.tail_cnt)) <= 3'd4))
        else $error("command size out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/utf8_to_utf16_sanitizing_transcoder.sv
`default_nettype none
// An accepted byte passes through the command queue and the back's command
// registers before its first code unit reaches m_valid. Input takes one byte
// per cycle while the command queue has room; the output register sends one
// code unit per cycle unless m_ready stalls it, and a byte produces at most
// four units. Reset (aresetn low at a clock edge) empties the queue, drops any
// pending partial sequence and clears m_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// utf8_to_utf16_sanitizing_transcoder
// UTF-8 byte stream to UTF-16 code units, with U+FFFD for malformed input.
// ----------------------------------------------------------------------------
module utf8_to_utf16_sanitizing_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_code_unit,
    output logic             m_end_of_string
);

    // The front classifies each item against the pending multi-byte sequence
    // and, when the item produces output, pushes one command: a count of
    // replacement units followed by zero, one or two literal units, plus the
    // end-of-string flag. Items that only extend a sequence push nothing.
    // The queue lets the front keep taking bytes while the back is still
    // draining a multi-unit command or the consumer is stalling.
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_head_valid;
    u8u16_pkg::cmd_t q_push_cmd;
    u8u16_pkg::cmd_t q_head_cmd;

    u8u16_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_final_byte (s_final_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    // Depth must be a power of two, at least two.
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // The back loads the next command in the same cycle that it sends the
    // last unit of the current one, so back-to-back commands leave no bubble.
    u8u16_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (q_head_valid),
        .head_cmd        (q_head_cmd),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_end_of_string (m_end_of_string)
    );

endmodule
`default_nettype wire
